### rtl/core/dps_pkg.sv
package dps_pkg;

   // Defaults and fixed field widths
   localparam int MAX_PROCS_DEF = 16;
   localparam int ID_W          = 16;
   localparam int PRIO_W        = 16;
   localparam int TIME_W        = 16;
   localparam int DECAY_W       = 8;
   localparam int STATUS_W      = 3;
   localparam int LIVE_W        = 5;

   localparam logic [DECAY_W-1:0] DECAY_RESET = 8'd3;
   localparam logic signed [PRIO_W-1:0] PRIO_MIN = 16'sh8000;

   // Item kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STAT_LOADED   = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_RAN      = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FINISHED = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_BAD_NEED = 3'd5;

   // One task slot as stored in the slot RAM
   typedef struct packed {
      logic [ID_W-1:0]          id;
      logic signed [PRIO_W-1:0] prio;
      logic [TIME_W-1:0]        remaining;
      logic [TIME_W-1:0]        used;
   } slot_type;

   // Controller to selector
   typedef struct packed {
      logic clear;      // start a new search
      logic chk_vld;    // RAM read data is valid this cycle
      logic find_free;  // look for the first empty slot instead of the best task
      logic slot_vld;   // valid bit of the slot being checked
   } pick_ctl_type;

   // Scheduler sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

### rtl/core/dps_req_if.sv
interface dps_req_if;
   import dps_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     kind;
   logic [ID_W-1:0]          task_id;
   logic signed [PRIO_W-1:0] start_priority;
   logic [TIME_W-1:0]        need_time;

   modport source (
      output valid, kind, task_id, start_priority, need_time,
      input  ready
   );

   modport sink (
      input  valid, kind, task_id, start_priority, need_time,
      output ready
   );

endinterface

### rtl/core/dps_rsp_if.sv
interface dps_rsp_if;
   import dps_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic [ID_W-1:0]          ran_id;
   logic signed [PRIO_W-1:0] new_priority;
   logic [TIME_W-1:0]        used_time;
   logic [TIME_W-1:0]        remaining_time;
   logic [LIVE_W-1:0]        live_tasks;

   modport source (
      output valid, status, ran_id, new_priority, used_time, remaining_time, live_tasks,
      input  ready
   );

   modport sink (
      input  valid, status, ran_id, new_priority, used_time, remaining_time, live_tasks,
      output ready
   );

endinterface

### rtl/core/dps_ram.sv
module dps_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/core/dps_pick.sv
module dps_pick #(
   parameter int MAX_PROCS = dps_pkg::MAX_PROCS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dps_pkg::pick_ctl_type        ctl,
   input  logic [$clog2(MAX_PROCS)-1:0] chk_idx,
   input  dps_pkg::slot_type            rd_slot,
   output logic                         found,
   output logic [$clog2(MAX_PROCS)-1:0] best_idx,
   output dps_pkg::slot_type            best_slot
);
   import dps_pkg::*;

   localparam int IDX_W = $clog2(MAX_PROCS);

   logic             found_ff, found_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   slot_type         best_ff, best_in;
   logic             take;

   // Candidate test: first empty slot for a load, strictly higher priority for a tick,
   // so the lowest slot wins a tie
   always_comb begin
      if (ctl.find_free) begin
         take = ctl.chk_vld && !ctl.slot_vld && !found_ff;
      end else begin
         take = ctl.chk_vld && ctl.slot_vld && (!found_ff || (rd_slot.prio > best_ff.prio));
      end
   end

   always_comb begin
      found_in    = found_ff;
      best_idx_in = best_idx_ff;
      best_in     = best_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in    = 1'b1;
         best_idx_in = chk_idx;
         best_in     = rd_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
   end

   assign found     = found_ff;
   assign best_idx  = best_idx_ff;
   assign best_slot = best_ff;

endmodule

### rtl/core/dynamic_priority_scheduler.sv
// Dynamic priority scheduler. Task slots (id, signed priority, remaining and used
// slices) live in a single-port-read slot RAM with valid bits in flops. A load item
// places a task in the lowest free slot (status full or bad need if it cannot); a tick
// runs the valid task with the highest priority, lowest slot on a tie, for one slice,
// then decays its priority by csr_wr_data's last written value (reset 3, saturating at
// -32768) or retires it when no time remains. Every item scans all MAX_PROCS slots,
// one RAM read per cycle, then writes back, and no new item is taken before that. A
// result waits in an output register, so the next item may be taken while it is pending;
// that item's writeback then waits until the older result has transferred.
// csr_wr_en must only be raised while no item is in flight.
module dynamic_priority_scheduler #(
   parameter int MAX_PROCS = dps_pkg::MAX_PROCS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   dps_req_if.sink                     req_ch,
   dps_rsp_if.source                   rsp_ch,
   input  logic                        csr_wr_en,
   input  logic [dps_pkg::DECAY_W-1:0] csr_wr_data
);
   import dps_pkg::*;

   localparam int IDX_W = $clog2(MAX_PROCS);
   localparam int CNT_W = $clog2(MAX_PROCS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PROCS - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_PROCS);

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [ID_W-1:0]          ran_id;
      logic signed [PRIO_W-1:0] new_priority;
      logic [TIME_W-1:0]        used_time;
      logic [TIME_W-1:0]        remaining_time;
      logic [LIVE_W-1:0]        live_tasks;
   } result_type;

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         addr_ff, addr_in;
   logic                     chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]         chk_idx_ff, chk_idx_in;
   logic [MAX_PROCS-1:0]     valid_ff, valid_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [DECAY_W-1:0]       decay_ff;
   logic                     kind_ff;
   logic [ID_W-1:0]          id_ff;
   logic signed [PRIO_W-1:0] prio_ff;
   logic [TIME_W-1:0]        need_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   result_type               rsp_ff, rsp_in;

   logic                     req_ready;
   logic                     accept;
   logic                     ram_rd_en;
   logic                     pick_clear;
   logic                     fire;
   logic                     ram_wr_en;
   slot_type                 wr_slot;
   slot_type                 rd_slot;
   slot_type                 best_slot;
   logic                     found;
   logic [IDX_W-1:0]         best_idx;
   pick_ctl_type             pick_ctl;
   logic [TIME_W-1:0]        used_nx;
   logic [TIME_W-1:0]        rem_nx;
   logic signed [PRIO_W:0]   prio_diff;
   logic signed [PRIO_W-1:0] prio_nx;

   assign accept = req_ch.valid && req_ready;
   assign fire   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   // Sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_ch.valid) state_in = ST_SCAN;
         ST_SCAN:  if (addr_ff == LAST_IDX) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_DONE;
         ST_DONE:  if (fire) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer: outputs
   always_comb begin
      req_ready  = 1'b0;
      ram_rd_en  = 1'b0;
      pick_clear = 1'b0;
      chk_vld_in = 1'b0;
      chk_idx_in = addr_ff;
      addr_in    = addr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = !reset;   // closed while in reset
            pick_clear = 1'b1;
            addr_in    = '0;
         end
         ST_SCAN: begin
            ram_rd_en  = 1'b1;
            chk_vld_in = 1'b1;
            addr_in    = addr_ff + 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign req_ch.ready = req_ready;

   // Slot storage
   dps_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (MAX_PROCS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (best_idx),
      .wr_data (wr_slot),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_slot)
   );

   // Best-slot search over the returning read data
   always_comb begin
      pick_ctl.clear     = pick_clear;
      pick_ctl.chk_vld   = chk_vld_ff;
      pick_ctl.find_free = (kind_ff == KIND_LOAD);
      pick_ctl.slot_vld  = valid_ff[chk_idx_ff];
   end

   dps_pick #(
      .MAX_PROCS (MAX_PROCS)
   ) u_pick (
      .clock     (clock),
      .reset     (reset),
      .ctl       (pick_ctl),
      .chk_idx   (chk_idx_ff),
      .rd_slot   (rd_slot),
      .found     (found),
      .best_idx  (best_idx),
      .best_slot (best_slot)
   );

   // Slice arithmetic with saturating decay
   always_comb begin
      used_nx   = best_slot.used + 1'b1;
      rem_nx    = best_slot.remaining - 1'b1;
      prio_diff = $signed({best_slot.prio[PRIO_W-1], best_slot.prio})
                - $signed({{(PRIO_W + 1 - DECAY_W){1'b0}}, decay_ff});
      if (prio_diff[PRIO_W] != prio_diff[PRIO_W-1]) begin
         prio_nx = PRIO_MIN;
      end else begin
         prio_nx = prio_diff[PRIO_W-1:0];
      end
   end

   // Writeback and result
   always_comb begin
      valid_in     = valid_ff;
      count_in     = count_ff;
      ram_wr_en    = 1'b0;
      wr_slot      = best_slot;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (fire) begin
         rsp_valid_in          = 1'b1;
         rsp_in.status         = STAT_LOADED;
         rsp_in.ran_id         = '0;
         rsp_in.new_priority   = '0;
         rsp_in.used_time      = '0;
         rsp_in.remaining_time = '0;
         if (kind_ff == KIND_LOAD) begin
            if (count_ff == FULL_CNT) begin
               rsp_in.status = STAT_FULL;
            end else if (need_ff == '0) begin
               rsp_in.status = STAT_BAD_NEED;
            end else begin
               ram_wr_en          = 1'b1;
               wr_slot.id         = id_ff;
               wr_slot.prio       = prio_ff;
               wr_slot.remaining  = need_ff;
               wr_slot.used       = '0;
               valid_in[best_idx] = 1'b1;
               count_in           = count_ff + 1'b1;
            end
         end else if (!found) begin
            rsp_in.status = STAT_EMPTY;
         end else if (rem_nx == '0) begin
            // last slice: retire without decay
            valid_in[best_idx]  = 1'b0;
            count_in            = count_ff - 1'b1;
            rsp_in.status       = STAT_FINISHED;
            rsp_in.ran_id       = best_slot.id;
            rsp_in.new_priority = best_slot.prio;
            rsp_in.used_time    = used_nx;
         end else begin
            ram_wr_en             = 1'b1;
            wr_slot.prio          = prio_nx;
            wr_slot.remaining     = rem_nx;
            wr_slot.used          = used_nx;
            rsp_in.status         = STAT_RAN;
            rsp_in.ran_id         = best_slot.id;
            rsp_in.new_priority   = prio_nx;
            rsp_in.used_time      = used_nx;
            rsp_in.remaining_time = rem_nx;
         end
         rsp_in.live_tasks = LIVE_W'(count_in);
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         addr_ff      <= '0;
         chk_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         decay_ff     <= DECAY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         chk_vld_ff   <= chk_vld_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            decay_ff <= csr_wr_data;
         end
      end
      chk_idx_ff <= chk_idx_in;
      rsp_ff     <= rsp_in;
      if (accept) begin
         kind_ff <= req_ch.kind;
         id_ff   <= req_ch.task_id;
         prio_ff <= req_ch.start_priority;
         need_ff <= req_ch.need_time;
      end
   end

   // Result channel
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_ff.status;
   assign rsp_ch.ran_id         = rsp_ff.ran_id;
   assign rsp_ch.new_priority   = rsp_ff.new_priority;
   assign rsp_ch.used_time      = rsp_ff.used_time;
   assign rsp_ch.remaining_time = rsp_ff.remaining_time;
   assign rsp_ch.live_tasks     = rsp_ff.live_tasks;

endmodule

### rtl/core/dps_checker.sv
module dps_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [dps_pkg::STATUS_W-1:0]       rsp_status,
   input logic [dps_pkg::ID_W-1:0]           rsp_ran_id,
   input logic signed [dps_pkg::PRIO_W-1:0]  rsp_new_priority,
   input logic [dps_pkg::TIME_W-1:0]         rsp_used_time,
   input logic [dps_pkg::TIME_W-1:0]         rsp_remaining_time,
   input logic [dps_pkg::LIVE_W-1:0]         rsp_live_tasks
);
   import dps_pkg::*;

   // A pending result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_ran_id)
         && $stable(rsp_new_priority) && $stable(rsp_used_time)
         && $stable(rsp_remaining_time) && $stable(rsp_live_tasks))
      else $error("result changed while stalled");

   // The slot scan keeps the input side closed after a transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again during slot scan");

   // A new result only appears after a busy cycle of the scan
   a_rsp_after_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result without a preceding scan");

   // An empty tick means the table held no task
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_EMPTY) |-> (rsp_live_tasks == '0))
      else $error("empty status with live tasks");

endmodule

bind dynamic_priority_scheduler dps_checker u_dps_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_status         (rsp_ch.status),
   .rsp_ran_id         (rsp_ch.ran_id),
   .rsp_new_priority   (rsp_ch.new_priority),
   .rsp_used_time      (rsp_ch.used_time),
   .rsp_remaining_time (rsp_ch.remaining_time),
   .rsp_live_tasks     (rsp_ch.live_tasks)
);

### test/dynamic_priority_scheduler_tb.sv
`timescale 1ns / 1ps

module dynamic_priority_scheduler_tb;
   import dps_pkg::*;

   localparam int SLOTS       = MAX_PROCS_DEF;
   localparam int SETTLE      = 2 * (MAX_PROCS_DEF + 4);
   localparam int QUIET_LIMIT = 4000;
   localparam int RAND_ITEMS  = 125;

   // One pending request as queued for the driver
   typedef struct {
      logic                     kind;
      logic [ID_W-1:0]          task_id;
      logic signed [PRIO_W-1:0] start_priority;
      logic [TIME_W-1:0]        need_time;
      bit                       hold;   // wait for all results before sending
   } job_type;

   // Expected response fields
   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [ID_W-1:0]          ran_id;
      logic signed [PRIO_W-1:0] new_priority;
      logic [TIME_W-1:0]        used_time;
      logic [TIME_W-1:0]        remaining_time;
      logic [LIVE_W-1:0]        live_tasks;
   } outcome_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [DECAY_W-1:0]  csr_wr_data = '0;

   dps_req_if req_ch ();
   dps_rsp_if rsp_ch ();

   dynamic_priority_scheduler u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   job_type     job_q[$];
   outcome_type outcome_q[$];
   int          fail_count     = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          quiet_cycles   = 0;
   bit          req_taken      = 1'b0;
   bit          timed_out;

   assign timed_out = (quiet_cycles >= QUIET_LIMIT);

   // Scheduler shadow state
   bit                       slot_on    [SLOTS];
   logic [ID_W-1:0]          slot_tid   [SLOTS];
   logic signed [PRIO_W-1:0] slot_prio  [SLOTS];
   logic [TIME_W-1:0]        slot_left  [SLOTS];
   logic [TIME_W-1:0]        slot_spent [SLOTS];
   int                       live_count = 0;
   logic [DECAY_W-1:0]       decay_now  = DECAY_RESET;

   // Apply one request to the shadow table and return the response it produces
   function automatic outcome_type sched_outcome(logic kind, logic [ID_W-1:0] tid,
                                                 logic signed [PRIO_W-1:0] prio,
                                                 logic [TIME_W-1:0] need);
      outcome_type o;
      int          free_slot;
      int          best;
      int          np;
      o         = '0;
      free_slot = -1;
      best      = -1;
      if (kind == KIND_LOAD) begin
         for (int i = SLOTS - 1; i >= 0; i--)
            if (!slot_on[i]) free_slot = i;
         if (free_slot < 0) begin
            o.status = STAT_FULL;
         end else if (need == 0) begin
            o.status = STAT_BAD_NEED;
         end else begin
            slot_on[free_slot]    = 1'b1;
            slot_tid[free_slot]   = tid;
            slot_prio[free_slot]  = prio;
            slot_left[free_slot]  = need;
            slot_spent[free_slot] = '0;
            live_count++;
            o.status = STAT_LOADED;
         end
      end else begin
         // highest priority wins, strict compare keeps the lowest slot on a tie
         for (int i = 0; i < SLOTS; i++)
            if (slot_on[i] && (best < 0 || slot_prio[i] > slot_prio[best])) best = i;
         if (best < 0) begin
            o.status = STAT_EMPTY;
         end else begin
            o.ran_id         = slot_tid[best];
            o.used_time      = slot_spent[best] + 1'b1;
            o.remaining_time = slot_left[best] - 1'b1;
            if (o.remaining_time == 0) begin
               // retiring task keeps the priority it ran with
               slot_on[best]  = 1'b0;
               live_count--;
               o.status       = STAT_FINISHED;
               o.new_priority = slot_prio[best];
            end else begin
               np = int'(slot_prio[best]) - int'(decay_now);
               if (np < int'(PRIO_MIN)) np = int'(PRIO_MIN);
               slot_prio[best]  = PRIO_W'(np);
               slot_spent[best] = o.used_time;
               slot_left[best]  = o.remaining_time;
               o.status         = STAT_RAN;
               o.new_priority   = PRIO_W'(np);
            end
         end
      end
      o.live_tasks = LIVE_W'(live_count);
      return o;
   endfunction

   function automatic job_type random_job();
      job_type j;
      int      r;
      j.kind    = ($urandom_range(99) < 55) ? KIND_TICK : KIND_LOAD;
      j.task_id = ID_W'($urandom);
      // priorities: extremes, near the floor, tight band for ties, anything
      case ($urandom_range(3))
         0: begin
            case ($urandom_range(3))
               0: j.start_priority = PRIO_MIN;
               1: j.start_priority = 16'sh7fff;
               2: j.start_priority = -16'sd1;
               default: j.start_priority = '0;
            endcase
         end
         1: j.start_priority = PRIO_MIN + PRIO_W'($urandom_range(600));
         2: j.start_priority = PRIO_W'($urandom_range(16) - 8);
         default: j.start_priority = PRIO_W'($urandom);
      endcase
      r = $urandom_range(99);
      if (r < 5)       j.need_time = '0;
      else if (r < 7)  j.need_time = '1;
      else if (r < 9)  j.need_time = TIME_W'($urandom);
      else if (r < 25) j.need_time = TIME_W'($urandom_range(40, 7));
      else             j.need_time = TIME_W'($urandom_range(6, 1));
      j.hold = ($urandom_range(49) == 0);
      return j;
   endfunction

   task automatic add_job(logic kind, logic [ID_W-1:0] tid,
                          logic signed [PRIO_W-1:0] prio, logic [TIME_W-1:0] need);
      job_type j;
      j.kind           = kind;
      j.task_id        = tid;
      j.start_priority = prio;
      j.need_time      = need;
      j.hold           = 1'b0;
      job_q.push_back(j);
   endtask

   task automatic check_field(string name, logic signed [31:0] want,
                              logic signed [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Wait until every request is sent and answered, then let the pipe settle
   task automatic drain();
      while ((job_q.size() != 0 || outcome_q.size() != 0 || req_ch.valid) && !timed_out)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_decay(logic [DECAY_W-1:0] v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      decay_now    = v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_phase(logic [DECAY_W-1:0] decay, int idle, int stall);
      drain();
      set_decay(decay);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      for (int n = 0; n < RAND_ITEMS; n++) job_q.push_back(random_job());
   endtask

   // Request driver: holds an item until its transfer, then picks the next one
   always @(negedge clock) begin
      job_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (job_q.size() != 0 && !(job_q[0].hold && outcome_q.size() != 0) &&
             $urandom_range(99) >= send_idle_pct) begin
            nxt = job_q.pop_front();
            req_ch.valid          <= 1'b1;
            req_ch.kind           <= nxt.kind;
            req_ch.task_id        <= nxt.task_id;
            req_ch.start_priority <= nxt.start_priority;
            req_ch.need_time      <= nxt.need_time;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response back-pressure
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: check responses, predict accepted requests, watchdog
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         req_taken    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (outcome_q.size() == 0) begin
               $display("%0t: response with none expected, status %0d", $time,
                        rsp_ch.status);
               fail_count++;
            end else begin
               want = outcome_q.pop_front();
               check_field("status", want.status, rsp_ch.status);
               check_field("ran_id", want.ran_id, rsp_ch.ran_id);
               check_field("new_priority", $signed(want.new_priority),
                           $signed(rsp_ch.new_priority));
               check_field("used_time", want.used_time, rsp_ch.used_time);
               check_field("remaining_time", want.remaining_time, rsp_ch.remaining_time);
               check_field("live_tasks", want.live_tasks, rsp_ch.live_tasks);
            end
         end
         if (req_ch.valid && req_ch.ready)
            outcome_q.push_back(sched_outcome(req_ch.kind, req_ch.task_id,
                                              req_ch.start_priority, req_ch.need_time));
         req_taken <= req_ch.valid && req_ch.ready;
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_ch.valid          = 1'b0;
      req_ch.kind           = KIND_LOAD;
      req_ch.task_id        = '0;
      req_ch.start_priority = '0;
      req_ch.need_time      = '0;
      rsp_ch.ready          = 1'b0;
      for (int i = 0; i < SLOTS; i++) slot_on[i] = 1'b0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty tick, zero need, extremes, finish, floor saturation, ties, full
      add_job(KIND_TICK, 16'h0000, 16'sh0000, 16'h0000);
      add_job(KIND_LOAD, 16'h1234, 16'sh0000, 16'h0000);
      add_job(KIND_LOAD, 16'hffff, 16'sh7fff, 16'h0001);
      add_job(KIND_LOAD, 16'h0000, PRIO_MIN, 16'hffff);
      add_job(KIND_TICK, 16'hffff, 16'sh7fff, 16'hffff);
      add_job(KIND_TICK, 16'h0000, 16'sh0000, 16'h0000);
      add_job(KIND_LOAD, 16'h00a5, 16'sh0005, 16'h0002);
      add_job(KIND_LOAD, 16'h005a, 16'sh0005, 16'h0002);
      add_job(KIND_TICK, 16'h0000, 16'sh0000, 16'h0000);
      add_job(KIND_TICK, 16'h0000, 16'sh0000, 16'h0000);
      add_job(KIND_TICK, 16'h0000, 16'sh0000, 16'h0000);
      // two tasks left; fill the rest of the table
      for (int n = 0; n < SLOTS - 2; n++)
         add_job(KIND_LOAD, ID_W'($urandom), PRIO_W'($urandom),
                 TIME_W'($urandom_range(9, 1)));
      add_job(KIND_LOAD, 16'h7777, 16'sh0001, 16'h0003);
      add_job(KIND_LOAD, 16'h8888, 16'sh0001, 16'h0000);

      // Random phases across decay settings and flow-control profiles
      random_phase(8'd0, 0, 0);
      random_phase(8'd255, 71, 0);
      random_phase(DECAY_W'($urandom_range(254, 1)), 0, 71);
      random_phase(8'd1, 9, 9);
      drain();

      if (timed_out)
         $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      if (outcome_q.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, outcome_q.size());
         fail_count++;
      end
      if (timed_out || fail_count != 0)
         $display("TB_ERROR");
      else
         $display("TB_OK");
      $finish;
   end

endmodule
